// File: rtl/csw_pkg.sv
// ----------------------------------------------------------------------------
// csw_pkg: shared types and constants of the contour search window unit
// Fixed-point formats, derived datapath widths, action and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csw_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS  = 4;
  localparam int OFFSET_FRAC_BITS = 8;

  // Field widths
  localparam int COORD_W  = 18;
  localparam int OFFSET_W = 12;
  localparam int FRAME_W  = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Derived datapath widths
  localparam int SCALE_W  = OFFSET_W + 1;
  localparam int SCALE_ONE = 1 << OFFSET_FRAC_BITS;
  localparam int DIFF_W   = COORD_W;
  localparam int SUM_W    = COORD_W + 1;
  localparam int PROD_W   = DIFF_W + SCALE_W;
  localparam int NUM_W    = PROD_W + 2;
  localparam int CORNER_SHIFT = COORD_FRAC_BITS + 1 + OFFSET_FRAC_BITS;
  localparam int SIZE_SHIFT   = COORD_FRAC_BITS + OFFSET_FRAC_BITS;
  localparam int CORNER_W = NUM_W - CORNER_SHIFT;
  localparam int SIZE_W   = PROD_W - SIZE_SHIFT;
  localparam int CLIP_W   = SIZE_W + 2;

  // Reset values of the configuration registers
  localparam logic [FRAME_W-1:0]  FRAME_WIDTH_RST   = FRAME_W'(640);
  localparam logic [FRAME_W-1:0]  FRAME_HEIGHT_RST  = FRAME_W'(480);
  localparam logic [OFFSET_W-1:0] EXPAND_OFFSET_RST = '0;

  // Input actions
  typedef enum logic [1:0] {
    ACT_POINT    = 2'd0,
    ACT_LAST     = 2'd1,
    ACT_APPEARED = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_EXPAND_OFFSET = 2'd2
  } cfg_reg_t;

  // Load strobes for the per-axis datapath stages
  typedef struct packed {
    logic load_prod;
    logic load_win;
  } csw_adv_t;

endpackage

`default_nettype wire

// File: rtl/csw_axis.sv
// ----------------------------------------------------------------------------
// csw_axis: window arithmetic for one axis
// Scales the half extent around the centre, truncates corner and size toward
// zero, then clips both against zero and the frame edge.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_axis
  import csw_pkg::*;
(
  input  wire logic                       clk,
  input  wire csw_adv_t                   adv,
  input  wire logic signed [COORD_W-1:0]  mn,
  input  wire logic signed [COORD_W-1:0]  mx,
  input  wire logic        [OFFSET_W-1:0] offset,
  input  wire logic        [FRAME_W-1:0]  frame,
  output logic             [FRAME_W-1:0]  pos,
  output logic             [FRAME_W-1:0]  len,
  output logic                            nonempty
);

  logic        [SCALE_W-1:0]  scale;
  logic signed [SUM_W-1:0]    diff_full;
  logic        [DIFF_W-1:0]   diff;
  logic signed [SUM_W-1:0]    sum_c;
  logic        [PROD_W-1:0]   prod_c;

  logic        [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    sum;

  logic signed [NUM_W-1:0]    num;
  logic signed [NUM_W-1:0]    num_biased;
  logic signed [NUM_W-1:0]    num_shifted;
  logic signed [CORNER_W-1:0] corner_c;
  logic        [SIZE_W-1:0]   size_c;

  logic signed [CORNER_W-1:0] corner;
  logic        [SIZE_W-1:0]   size;

  logic signed [CLIP_W-1:0]   c0;
  logic signed [CLIP_W-1:0]   s0;
  logic signed [CLIP_W-1:0]   c1;
  logic signed [CLIP_W-1:0]   s1;
  logic signed [CLIP_W-1:0]   s2;
  logic signed [CLIP_W-1:0]   f;

  // Extent, centre sum and scaled extent
  always_comb begin
    scale     = SCALE_W'(SCALE_ONE) + SCALE_W'(offset);
    diff_full = SUM_W'(mx) - SUM_W'(mn);
    diff      = diff_full[DIFF_W-1:0];
    sum_c     = SUM_W'(mn) + SUM_W'(mx);
    prod_c    = PROD_W'(diff) * PROD_W'(scale);
  end

  always_ff @(posedge clk) begin
    if (adv.load_prod) begin
      prod <= prod_c;
      sum  <= sum_c;
    end
  end

  // Corner and size, each truncated toward zero
  always_comb begin
    num = ($signed({{(NUM_W-SUM_W){sum[SUM_W-1]}}, sum}) <<< OFFSET_FRAC_BITS)
        - $signed({2'b00, prod});
    num_biased = num[NUM_W-1] ? num + NUM_W'((1 << CORNER_SHIFT) - 1) : num;
    num_shifted = num_biased >>> CORNER_SHIFT;
    corner_c = num_shifted[CORNER_W-1:0];
    size_c   = prod[PROD_W-1:SIZE_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (adv.load_win) begin
      corner <= corner_c;
      size   <= size_c;
    end
  end

  // Clip against zero, then against the far frame edge
  always_comb begin
    c0 = $signed({{(CLIP_W-CORNER_W){corner[CORNER_W-1]}}, corner});
    s0 = $signed({{(CLIP_W-SIZE_W){1'b0}}, size});
    f  = $signed({{(CLIP_W-FRAME_W){1'b0}}, frame});
    if (c0 < 0) begin
      s1 = s0 + c0;
      c1 = '0;
    end else begin
      s1 = s0;
      c1 = c0;
    end
    if (c1 + s1 > f) begin
      s2 = f - c1;
    end else begin
      s2 = s1;
    end
    nonempty = (s2 > 0);
    pos      = c1[FRAME_W-1:0];
    len      = s2[FRAME_W-1:0];
  end

endmodule

`default_nettype wire

// File: rtl/contour_search_window_unit.sv
// Contour search window unit.
// Throughput: one beat per cycle while the output is not stalled; each beat
// other than a point passes input, snapshot, product and window registers
// before the result register; a point beat leaves after the input register.
// Reset: synchronous; empties the pipe, clears min/max, restores frame
// 640x480 and zero enlargement, and the next point starts a new contour.
// ----------------------------------------------------------------------------
// contour_search_window_unit: bounding box search window of a contour
// Tracks min/max of contour points and emits a scaled, clipped rectangle on
// the last point, the full frame or an empty rectangle on request.
// ----------------------------------------------------------------------------
`default_nettype none

module contour_search_window_unit
  import csw_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration
  input  wire logic                       cfg_write,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 action,
  input  wire logic signed [COORD_W-1:0]  point_x,
  input  wire logic signed [COORD_W-1:0]  point_y,
  // output channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [FRAME_W-1:0]              rect_x,
  output logic [FRAME_W-1:0]              rect_y,
  output logic [FRAME_W-1:0]              rect_width,
  output logic [FRAME_W-1:0]              rect_height
);

  // Configuration registers
  logic [FRAME_W-1:0]  frame_width;
  logic [FRAME_W-1:0]  frame_height;
  logic [OFFSET_W-1:0] expand_offset;

  // Contour state
  logic signed [COORD_W-1:0] min_x, min_y, max_x, max_y;
  logic                      expect_first;
  logic signed [COORD_W-1:0] min_x_next, min_y_next, max_x_next, max_y_next;

  // Pipeline registers
  logic                      v0, v1, v2, v3;
  action_t                   a0, k1, k2, k3;
  logic signed [COORD_W-1:0] px0, py0;
  logic signed [COORD_W-1:0] min_x1, min_y1, max_x1, max_y1;

  // Handshake
  logic out_load, ld1, ld2, ld3, ld4;
  logic free0, free1, free2, free3, leave0;
  csw_adv_t adv;

  // Axis results
  logic [FRAME_W-1:0] ax_pos, ax_len, ay_pos, ay_len;
  logic               ax_ok, ay_ok;

  logic [FRAME_W-1:0] rect_x_next, rect_y_next, rect_width_next, rect_height_next;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      expand_offset <= EXPAND_OFFSET_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[FRAME_W-1:0];
        REG_EXPAND_OFFSET: expand_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipe wherever the next stage is empty or moving
  always_comb begin
    out_load = !out_valid || !out_stall;
    ld4      = v3 && out_load;
    free3    = !v3 || ld4;
    ld3      = v2 && free3;
    free2    = !v2 || ld3;
    ld2      = v1 && free2;
    free1    = !v1 || ld2;
    leave0   = v0 && ((a0 == ACT_POINT) || free1);
    ld1      = leave0 && (a0 != ACT_POINT);
    free0    = !v0 || leave0;
    in_stall = !free0;
    adv.load_prod = ld2;
    adv.load_win  = ld3;
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (free0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free0 && in_valid) begin
      a0  <= action_t'(action);
      px0 <= point_x;
      py0 <= point_y;
    end
  end

  // Fold the point into the running box
  always_comb begin
    if (expect_first) begin
      min_x_next = px0;
      max_x_next = px0;
      min_y_next = py0;
      max_y_next = py0;
    end else begin
      min_x_next = (px0 < min_x) ? px0 : min_x;
      max_x_next = (px0 > max_x) ? px0 : max_x;
      min_y_next = (py0 < min_y) ? py0 : min_y;
      max_y_next = (py0 > max_y) ? py0 : max_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x        <= '0;
      min_y        <= '0;
      max_x        <= '0;
      max_y        <= '0;
      expect_first <= 1'b1;
    end else if (leave0) begin
      expect_first <= (a0 != ACT_POINT);
      if (a0 == ACT_POINT || a0 == ACT_LAST) begin
        min_x <= min_x_next;
        min_y <= min_y_next;
        max_x <= max_x_next;
        max_y <= max_y_next;
      end
    end
  end

  // Snapshot the finished box for result beats
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (free1) v1 <= ld1;
      if (free2) v2 <= ld2;
      if (free3) v3 <= ld3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      k1     <= a0;
      min_x1 <= min_x_next;
      min_y1 <= min_y_next;
      max_x1 <= max_x_next;
      max_y1 <= max_y_next;
    end
    if (ld2) k2 <= k1;
    if (ld3) k3 <= k2;
  end

  // Per-axis window arithmetic
  csw_axis u_axis_x (
    .clk      (clk),
    .adv      (adv),
    .mn       (min_x1),
    .mx       (max_x1),
    .offset   (expand_offset),
    .frame    (frame_width),
    .pos      (ax_pos),
    .len      (ax_len),
    .nonempty (ax_ok)
  );

  csw_axis u_axis_y (
    .clk      (clk),
    .adv      (adv),
    .mn       (min_y1),
    .mx       (max_y1),
    .offset   (expand_offset),
    .frame    (frame_height),
    .pos      (ay_pos),
    .len      (ay_len),
    .nonempty (ay_ok)
  );

  // Select the result rectangle
  always_comb begin
    rect_x_next      = '0;
    rect_y_next      = '0;
    rect_width_next  = '0;
    rect_height_next = '0;
    case (k3)
      ACT_APPEARED: begin
        rect_width_next  = frame_width;
        rect_height_next = frame_height;
      end
      ACT_LAST: begin
        if (ax_ok && ay_ok) begin
          rect_x_next      = ax_pos;
          rect_y_next      = ay_pos;
          rect_width_next  = ax_len;
          rect_height_next = ay_len;
        end
      end
      default: ;
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      rect_x      <= rect_x_next;
      rect_y      <= rect_y_next;
      rect_width  <= rect_width_next;
      rect_height <= rect_height_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/csw_checker.sv
// ----------------------------------------------------------------------------
// csw_checker: port-level checks of the contour search window unit
// Watches the handshakes and the shape of result rectangles.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_checker
  import csw_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [FRAME_W-1:0] rect_x,
  input wire logic [FRAME_W-1:0] rect_y,
  input wire logic [FRAME_W-1:0] rect_width,
  input wire logic [FRAME_W-1:0] rect_height
);

  // Reset empties the pipe and frees the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rect_x) && $stable(rect_y)
      && $stable(rect_width) && $stable(rect_height))
    else $error("stalled result beat changed");

  // Input side keeps its beat while stalled
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input beat dropped while stalled");

  // A window off the origin always has a nonzero size
  a_corner_sized: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rect_x != '0 || rect_y != '0) |-> rect_width != '0
      && rect_height != '0)
    else $error("window off the origin with zero size");

endmodule

bind contour_search_window_unit csw_checker u_csw_checker (.*);

`default_nettype wire
